FILE: rtl/core/rvm_pkg.sv
// Shared types, constants and helpers for the rotation-vector-to-matrix block.
// No dependencies; used by every module in rtl/core.
package rvm_pkg;

  // Number of CORDIC micro-rotations (atan_f gives a zero angle past step 30)
  localparam int CordicSteps = 30;
  localparam int StepW       = 6;
  localparam int SqrtCells   = 32;
  localparam int DivCells    = 31;
  localparam int RedCells    = 5;

  localparam logic signed [34:0] OneQ30    = 35'sh040000000;
  localparam logic signed [34:0] PiQ30     = 35'sh0C90FDAA2;
  localparam logic signed [34:0] TwoPiQ30  = 35'sh1921FB544;
  localparam logic signed [34:0] HalfPiQ30 = 35'sh06487ED51;
  localparam logic signed [34:0] GainQ30   = 35'sh026DD3B6A;
  localparam logic [61:0]        TwoPiQ55  = 62'h3243F6A8885A309;

  localparam logic [31:0] AtanTab [16] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF
  };

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] angle_scale;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } out_t;

  // square root chain: radicand shifts out two bits per cell
  typedef struct packed {
    logic [63:0]      rad;
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] low;
    logic [30:0] quo;
  } div_lane_t;

  // axis normalization: three restoring dividers sharing one divisor
  typedef struct packed {
    div_lane_t [2:0] lane;
    logic [31:0]     len;
    logic [2:0]      neg;
  } div_t;

  // rotation chain: x/y vector, residual angle z, plus axis riding along
  typedef struct packed {
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic signed [34:0] z;
    logic [2:0][31:0]   u;
    logic               flip;
    logic               zero;
  } cor_t;

  function automatic logic signed [34:0] atan_f(input logic [StepW-1:0] idx);
    logic signed [34:0] r;
    if (idx < StepW'(16)) begin
      r = $signed({3'b000, AtanTab[idx[3:0]]});
    end else if (idx <= StepW'(30)) begin
      r = $signed((35'd1 << (StepW'(30) - idx)) - 35'd1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/rvm_sqrt_cell.sv
// One digit-pair step of the restoring integer square root.
// Depends on rvm_pkg.
module rvm_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rvm_pkg::sqrt_t data_i,
  output logic          valid_o,
  output rvm_pkg::sqrt_t data_o
);
  import rvm_pkg::*;

  logic        valid_q;
  sqrt_t       data_d, data_q;
  logic [35:0] cur, trial;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    cur    = {data_i.rem, data_i.rad[63:62]};
    trial  = {2'b00, data_i.root, 2'b01};
    data_d = data_i;
    data_d.rad = data_i.rad << 2;
    if (cur >= trial) begin
      data_d.rem  = 34'(cur - trial);
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.rem  = cur[33:0];
      data_d.root = {data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: rtl/core/rvm_div_cell.sv
// One quotient bit for each of the three axis dividers.
// Depends on rvm_pkg.
module rvm_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  rvm_pkg::div_t data_i,
  output logic         valid_o,
  output rvm_pkg::div_t data_o
);
  import rvm_pkg::*;

  logic        valid_q;
  div_t        data_d, data_q;
  logic [32:0] cur [3];
  logic [32:0] dvs;

  // shift in next numerator bit, subtract divisor when it fits
  always_comb begin
    data_d = data_i;
    dvs    = {1'b0, data_i.len};
    for (int k = 0; k < 3; k++) begin
      cur[k] = {data_i.lane[k].rem, data_i.lane[k].low[30]};
      data_d.lane[k].low = data_i.lane[k].low << 1;
      if (cur[k] >= dvs) begin
        data_d.lane[k].rem = 32'(cur[k] - dvs);
        data_d.lane[k].quo = {data_i.lane[k].quo[29:0], 1'b1};
      end else begin
        data_d.lane[k].rem = cur[k][31:0];
        data_d.lane[k].quo = {data_i.lane[k].quo[29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: rtl/core/rvm_cordic_cell.sv
// One CORDIC micro-rotation in rotation mode; step_i is tied per instance.
// Depends on rvm_pkg.
module rvm_cordic_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [rvm_pkg::StepW-1:0] step_i,
  input  logic                      valid_i,
  input  rvm_pkg::cor_t             data_i,
  output logic                      valid_o,
  output rvm_pkg::cor_t             data_o
);
  import rvm_pkg::*;

  logic               valid_q;
  cor_t               data_d, data_q;
  logic signed [34:0] xs, ys, at;

  // rotate toward zero residual angle
  always_comb begin
    xs     = data_i.x >>> step_i;
    ys     = data_i.y >>> step_i;
    at     = atan_f(step_i);
    data_d = data_i;
    if (!data_i.z[34]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: rtl/core/rotation_vector_to_matrix_top.sv
// Rotation vector to 3x3 rotation matrix (Rodrigues formula), fully pipelined.
// Depends on rvm_pkg, rvm_sqrt_cell, rvm_div_cell, rvm_cordic_cell.
//
// Takes one request per clock while not stalled and returns one matrix per
// request, in order. The chain holds 4 registers of scaling and squaring, 32
// square-root cells, 1 + 31 cells of axis division, 5 cells of angle reduction
// modulo 2*pi, 1 prep register, one cell per CORDIC step, then 4 registers of
// clamping, products and saturation, the last being the output register.
// The whole chain moves as one; it halts only while a finished matrix sits in
// the output register and the consumer stalls. A zero-length vector gives the
// identity matrix.
module rotation_vector_to_matrix_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rvm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rvm_pkg::out_t out_data_o
);
  import rvm_pkg::*;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [32:0] t;
    logic [2:0][31:0]   u;
    logic               zero;
  } post_t;

  typedef struct packed {
    logic [5:0][31:0] pp;
    logic [2:0][31:0] su;
    logic signed [31:0] c;
    logic signed [32:0] t;
    logic               zero;
  } m1_t;

  typedef struct packed {
    logic [5:0][32:0] tp;
    logic [2:0][31:0] su;
    logic signed [31:0] c;
    logic               zero;
  } m2_t;

  typedef struct packed {
    logic [61:0]      rem;
    logic [2:0][31:0] u;
    logic             zero;
  } red_t;

  function automatic logic signed [31:0] sat_f(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic adv;

  // global advance: chain moves unless the held result is stalled
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- scale, magnitude, square, sum ----------------
  logic                      f1_v_q, f2_v_q, f3_v_q, f4_v_q;
  logic signed [2:0][63:0]   f1_prod_q;
  logic [2:0][31:0]          f2_mag_q, f3_mag_q;
  logic [2:0]                f2_neg_q, f3_neg_q;
  logic [2:0][63:0]          f3_sq_q;
  sqrt_t                     f4_q;
  logic [2:0][31:0]          f2_mag_d;
  logic [2:0]                f2_neg_d;
  logic signed [63:0]        rnd [3];
  logic signed [32:0]        vsc [3];
  logic [32:0]               vmg [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k]      = f1_prod_q[k] + 64'sd1073741824;
      vsc[k]      = rnd[k][63:31];
      vmg[k]      = vsc[k][32] ? 33'(-vsc[k]) : vsc[k];
      f2_mag_d[k] = vmg[k][31:0];
      f2_neg_d[k] = vsc[k][32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_prod_q[0] <= in_data_i.rot_x * in_data_i.angle_scale;
      f1_prod_q[1] <= in_data_i.rot_y * in_data_i.angle_scale;
      f1_prod_q[2] <= in_data_i.rot_z * in_data_i.angle_scale;
      f2_mag_q     <= f2_mag_d;
      f2_neg_q     <= f2_neg_d;
      for (int k = 0; k < 3; k++) begin
        f3_sq_q[k] <= f2_mag_q[k] * f2_mag_q[k];
      end
      f3_mag_q  <= f2_mag_q;
      f3_neg_q  <= f2_neg_q;
      f4_q.rad  <= f3_sq_q[0] + f3_sq_q[1] + f3_sq_q[2];
      f4_q.rem  <= '0;
      f4_q.root <= '0;
      f4_q.mag  <= f3_mag_q;
      f4_q.neg  <= f3_neg_q;
    end
  end

  // ---------------- square root chain ----------------
  logic  sq_v [SqrtCells+1];
  sqrt_t sq_d [SqrtCells+1];

  assign sq_v[0] = f4_v_q;
  assign sq_d[0] = f4_q;

  for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
    rvm_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(sq_v[g]),
      .data_i (sq_d[g]),
      .valid_o(sq_v[g+1]),
      .data_o (sq_d[g+1])
    );
  end

  // ---------------- divider setup ----------------
  logic        d0_v_q;
  div_t        d0_q, d0_d;
  logic [61:0] num [3];

  always_comb begin
    d0_d.len = sq_d[SqrtCells].root;
    d0_d.neg = sq_d[SqrtCells].neg;
    for (int k = 0; k < 3; k++) begin
      num[k] = {sq_d[SqrtCells].mag[k], 30'b0}
             + {31'b0, sq_d[SqrtCells].root[31:1]};
      d0_d.lane[k].rem = {1'b0, num[k][61:31]};
      d0_d.lane[k].low = num[k][30:0];
      d0_d.lane[k].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_v_q <= 1'b0;
    end else if (adv) begin
      d0_v_q <= sq_v[SqrtCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d0_q <= d0_d;
    end
  end

  // ---------------- division chain ----------------
  logic dv_v [DivCells+1];
  div_t dv_d [DivCells+1];

  assign dv_v[0] = d0_v_q;
  assign dv_d[0] = d0_q;

  for (genvar g = 0; g < DivCells; g++) begin : g_div
    rvm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(dv_v[g]),
      .data_i (dv_d[g]),
      .valid_o(dv_v[g+1]),
      .data_o (dv_d[g+1])
    );
  end

  // ---------------- angle reduction modulo 2*pi ----------------
  logic rd_v [RedCells+1];
  red_t rd_d [RedCells+1];

  always_comb begin
    rd_d[0].rem  = {dv_d[DivCells].len, 30'b0};
    rd_d[0].zero = (dv_d[DivCells].len == '0);
    for (int k = 0; k < 3; k++) begin
      rd_d[0].u[k] = dv_d[DivCells].neg[k]
                   ? 32'(-{1'b0, dv_d[DivCells].lane[k].quo})
                   : {1'b0, dv_d[DivCells].lane[k].quo};
    end
  end
  assign rd_v[0] = dv_v[DivCells];

  for (genvar g = 0; g < RedCells; g++) begin : g_red
    localparam logic [61:0] Sub = TwoPiQ55 << (RedCells - 1 - g);
    red_t rq, rdn;

    always_comb begin
      rdn = rd_d[g];
      if (rd_d[g].rem >= Sub) begin
        rdn.rem = rd_d[g].rem - Sub;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rd_v[g+1] <= 1'b0;
      end else if (adv) begin
        rd_v[g+1] <= rd_v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rq <= rdn;
      end
    end
    assign rd_d[g+1] = rq;
  end

  // ---------------- CORDIC prep: round, wrap, fold ----------------
  logic               pr_v_q;
  cor_t               pr_q, pr_d;
  logic [61:0]        rsum;
  logic signed [34:0] ang;

  always_comb begin
    rsum      = rd_d[RedCells].rem + 62'(1 << 24);
    ang       = $signed({1'b0, rsum[58:25]});
    pr_d.flip = 1'b0;
    if (ang > PiQ30) begin
      ang = ang - TwoPiQ30;
    end
    if (ang > HalfPiQ30) begin
      ang       = ang - PiQ30;
      pr_d.flip = 1'b1;
    end else if (ang < -HalfPiQ30) begin
      ang       = ang + PiQ30;
      pr_d.flip = 1'b1;
    end
    pr_d.x    = GainQ30;
    pr_d.y    = '0;
    pr_d.z    = ang;
    pr_d.u    = rd_d[RedCells].u;
    pr_d.zero = rd_d[RedCells].zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (adv) begin
      pr_v_q <= rd_v[RedCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q <= pr_d;
    end
  end

  // ---------------- CORDIC chain ----------------
  logic cr_v [CordicSteps+1];
  cor_t cr_d [CordicSteps+1];

  assign cr_v[0] = pr_v_q;
  assign cr_d[0] = pr_q;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    rvm_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .step_i (StepW'(g)),
      .valid_i(cr_v[g]),
      .data_i (cr_d[g]),
      .valid_o(cr_v[g+1]),
      .data_o (cr_d[g+1])
    );
  end

  // ---------------- unfold and clamp sin/cos ----------------
  logic               po_v_q;
  post_t              po_q, po_d;
  logic signed [34:0] xf, yf, xc, yc;

  always_comb begin
    xf = cr_d[CordicSteps].flip ? -cr_d[CordicSteps].x : cr_d[CordicSteps].x;
    yf = cr_d[CordicSteps].flip ? -cr_d[CordicSteps].y : cr_d[CordicSteps].y;
    xc = (xf > OneQ30) ? OneQ30 : ((xf < -OneQ30) ? -OneQ30 : xf);
    yc = (yf > OneQ30) ? OneQ30 : ((yf < -OneQ30) ? -OneQ30 : yf);
    po_d.c    = xc[31:0];
    po_d.s    = yc[31:0];
    po_d.t    = 33'(OneQ30 - xc);
    po_d.u    = cr_d[CordicSteps].u;
    po_d.zero = cr_d[CordicSteps].zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      po_v_q <= 1'b0;
    end else if (adv) begin
      po_v_q <= cr_v[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      po_q <= po_d;
    end
  end

  // ---------------- axis products and sin*axis ----------------
  logic               m1_v_q;
  m1_t                m1_q, m1_d;
  logic signed [31:0] pa [6];
  logic signed [31:0] pb [6];
  logic signed [63:0] pw [6];
  logic signed [63:0] sw [3];

  always_comb begin
    pa[0] = po_q.u[0]; pb[0] = po_q.u[0];
    pa[1] = po_q.u[1]; pb[1] = po_q.u[1];
    pa[2] = po_q.u[2]; pb[2] = po_q.u[2];
    pa[3] = po_q.u[0]; pb[3] = po_q.u[1];
    pa[4] = po_q.u[0]; pb[4] = po_q.u[2];
    pa[5] = po_q.u[1]; pb[5] = po_q.u[2];
    for (int k = 0; k < 6; k++) begin
      pw[k]       = pa[k] * pb[k] + 64'sd536870912;
      m1_d.pp[k]  = pw[k][61:30];
    end
    for (int k = 0; k < 3; k++) begin
      sw[k]      = po_q.s * $signed(po_q.u[k]) + 64'sd536870912;
      m1_d.su[k] = sw[k][61:30];
    end
    m1_d.c    = po_q.c;
    m1_d.t    = po_q.t;
    m1_d.zero = po_q.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= po_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q <= m1_d;
    end
  end

  // ---------------- (1-c) times axis products ----------------
  logic               m2_v_q;
  m2_t                m2_q, m2_d;
  logic signed [64:0] tw [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      tw[k]      = m1_q.t * $signed(m1_q.pp[k]) + 65'sd536870912;
      m2_d.tp[k] = tw[k][62:30];
    end
    m2_d.su   = m1_q.su;
    m2_d.c    = m1_q.c;
    m2_d.zero = m1_q.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (adv) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_q <= m2_d;
    end
  end

  // ---------------- entries, saturation, output register ----------------
  logic               out_v_q;
  out_t               out_q, out_d;
  logic signed [33:0] cc, t0, t1, t2, t3, t4, t5, s0, s1, s2;

  always_comb begin
    cc = 34'(m2_q.c);
    t0 = 34'($signed(m2_q.tp[0]));
    t1 = 34'($signed(m2_q.tp[1]));
    t2 = 34'($signed(m2_q.tp[2]));
    t3 = 34'($signed(m2_q.tp[3]));
    t4 = 34'($signed(m2_q.tp[4]));
    t5 = 34'($signed(m2_q.tp[5]));
    s0 = 34'($signed(m2_q.su[0]));
    s1 = 34'($signed(m2_q.su[1]));
    s2 = 34'($signed(m2_q.su[2]));
    if (m2_q.zero) begin
      out_d     = '0;
      out_d.m00 = 32'sh40000000;
      out_d.m11 = 32'sh40000000;
      out_d.m22 = 32'sh40000000;
    end else begin
      out_d.m00 = sat_f(cc + t0);
      out_d.m01 = sat_f(t3 - s2);
      out_d.m02 = sat_f(t4 + s1);
      out_d.m10 = sat_f(t3 + s2);
      out_d.m11 = sat_f(cc + t1);
      out_d.m12 = sat_f(t5 - s0);
      out_d.m20 = sat_f(t4 - s1);
      out_d.m21 = sat_f(t5 + s0);
      out_d.m22 = sat_f(cc + t2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule

FILE: rtl/core/rvm_checker.sv
// Port-level checks for the rotation-vector-to-matrix top level.
// Depends on rvm_pkg; bound to rotation_vector_to_matrix_top below.
module rvm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input rvm_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rvm_pkg::out_t out_data_o
);
  import rvm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input side only stalls when a result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // while the input is stalled the chain is frozen, so the result holds
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while chain frozen");

  // an unstalled output never holds up the input
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

endmodule

bind rotation_vector_to_matrix_top rvm_checker u_rvm_checker (.*);
